@@ rtl/core/mdp_pkg.sv @@
package mdp_pkg;

  localparam int WORD_BITS = 32;
  localparam int LANES     = WORD_BITS / 2;
  localparam int LANE_W    = $clog2(LANES);
  localparam int GRP_SIZE  = 4;
  localparam int GROUPS    = LANES / GRP_SIZE;
  localparam int SHIFT_W   = LANE_W + 4;
  localparam int CNT_W     = 5;
  localparam int CMP_W     = 8;
  localparam int MODE_W    = 4;
  localparam int SUM_W     = 32;
  localparam int ELEM_W    = 16;
  localparam int ADDR_W    = 2;
  localparam int PDATA_W   = 32;

  // register byte addresses
  localparam logic [ADDR_W-1:0] REG_PRECISION_MODE = ADDR_W'(0);

  // precision mode codes
  localparam logic [MODE_W-1:0] MODE_A16B16 = 4'd0;
  localparam logic [MODE_W-1:0] MODE_A8B8   = 4'd1;
  localparam logic [MODE_W-1:0] MODE_A4B4   = 4'd2;
  localparam logic [MODE_W-1:0] MODE_A2B2   = 4'd3;
  localparam logic [MODE_W-1:0] MODE_A16B8  = 4'd4;
  localparam logic [MODE_W-1:0] MODE_A16B4  = 4'd5;
  localparam logic [MODE_W-1:0] MODE_A16B2  = 4'd6;
  localparam logic [MODE_W-1:0] MODE_A8B4   = 4'd7;
  localparam logic [MODE_W-1:0] MODE_A8B2   = 4'd8;
  localparam logic [MODE_W-1:0] MODE_A4B2   = 4'd9;

  typedef enum logic [1:0] {
    EW16,
    EW8,
    EW4,
    EW2
  } elem_w_t;

  typedef struct packed {
    logic    ok;
    elem_w_t a_w;
    elem_w_t b_w;
  } mode_dec_t;

  typedef struct packed {
    logic valid;
    logic last;
  } beat_ctl_t;

  function automatic mode_dec_t decode_mode(input logic [MODE_W-1:0] mode);
    mode_dec_t d;
    d.ok  = 1'b1;
    d.a_w = EW16;
    d.b_w = EW16;
    unique case (mode)
      MODE_A16B16: begin d.a_w = EW16; d.b_w = EW16; end
      MODE_A8B8:   begin d.a_w = EW8;  d.b_w = EW8;  end
      MODE_A4B4:   begin d.a_w = EW4;  d.b_w = EW4;  end
      MODE_A2B2:   begin d.a_w = EW2;  d.b_w = EW2;  end
      MODE_A16B8:  begin d.a_w = EW16; d.b_w = EW8;  end
      MODE_A16B4:  begin d.a_w = EW16; d.b_w = EW4;  end
      MODE_A16B2:  begin d.a_w = EW16; d.b_w = EW2;  end
      MODE_A8B4:   begin d.a_w = EW8;  d.b_w = EW4;  end
      MODE_A8B2:   begin d.a_w = EW8;  d.b_w = EW2;  end
      MODE_A4B2:   begin d.a_w = EW4;  d.b_w = EW2;  end
      default:     d.ok = 1'b0;
    endcase
    return d;
  endfunction

endpackage

@@ rtl/core/mdp_in_if.sv @@
interface mdp_in_if;
  import mdp_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] a_word;
  logic [WORD_BITS-1:0] b_word;
  logic [CNT_W-1:0]     elem_count;
  logic                 last;

  modport source (output valid, a_word, b_word, elem_count, last, input ready);
  modport sink   (input valid, a_word, b_word, elem_count, last, output ready);
endinterface

@@ rtl/core/mdp_out_if.sv @@
interface mdp_out_if;
  import mdp_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] dot_sum;

  modport source (output valid, dot_sum, input ready);
  modport sink   (input valid, dot_sum, output ready);
endinterface

@@ rtl/core/mdp_lane.sv @@
module mdp_lane
  import mdp_pkg::*;
(
  input  logic                    clk,
  input  logic                    en,
  input  logic [LANE_W-1:0]       lane_idx,
  input  mode_dec_t               mode_dec,
  input  logic [WORD_BITS-1:0]    a_word,
  input  logic [WORD_BITS-1:0]    b_word,
  input  logic [CNT_W-1:0]        elem_count,
  output logic signed [SUM_W-1:0] prod_r
);

  // pick element lane_idx of the given width and sign-extend it
  function automatic logic signed [ELEM_W-1:0] pick_elem(
    input logic [WORD_BITS-1:0] word,
    input logic [LANE_W-1:0]    idx,
    input elem_w_t              ew
  );
    logic [WORD_BITS-1:0]     sh;
    logic signed [ELEM_W-1:0] e;
    sh = '0;
    e  = '0;
    unique case (ew)
      EW16: begin
        sh = word >> {idx, 4'b0000};
        e  = sh[15:0];
      end
      EW8: begin
        sh = word >> SHIFT_W'({idx, 3'b000});
        e  = {{8{sh[7]}}, sh[7:0]};
      end
      EW4: begin
        sh = word >> SHIFT_W'({idx, 2'b00});
        e  = {{12{sh[3]}}, sh[3:0]};
      end
      EW2: begin
        sh = word >> SHIFT_W'({idx, 1'b0});
        e  = {{14{sh[1]}}, sh[1:0]};
      end
      default: e = '0;
    endcase
    return e;
  endfunction

  logic [CMP_W-1:0]         per_word;
  logic                     lane_on;
  logic signed [ELEM_W-1:0] a_elem;
  logic signed [ELEM_W-1:0] b_elem;
  logic signed [SUM_W-1:0]  prod_full;
  logic signed [SUM_W-1:0]  prod_nxt;

  // elements of the a side that fit into one word
  always_comb begin
    unique case (mode_dec.a_w)
      EW16:    per_word = CMP_W'(WORD_BITS / 16);
      EW8:     per_word = CMP_W'(WORD_BITS / 8);
      EW4:     per_word = CMP_W'(WORD_BITS / 4);
      EW2:     per_word = CMP_W'(WORD_BITS / 2);
      default: per_word = '0;
    endcase
  end

  assign lane_on = mode_dec.ok
                && (CMP_W'(lane_idx) < CMP_W'(elem_count))
                && (CMP_W'(lane_idx) < per_word);

  assign a_elem    = pick_elem(a_word, lane_idx, mode_dec.a_w);
  assign b_elem    = pick_elem(b_word, lane_idx, mode_dec.b_w);
  // full-width signed product of the two 16-bit elements
  assign prod_full = a_elem * b_elem;
  assign prod_nxt  = lane_on ? prod_full : '0;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

@@ rtl/core/mdp_merge.sv @@
module mdp_merge
  import mdp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  beat_ctl_t               s1_ctl,
  input  logic signed [SUM_W-1:0] prods [LANES],
  input  logic                    out_ready,
  output logic                    out_valid_r,
  output logic signed [SUM_W-1:0] dot_sum_r
);

  beat_ctl_t               s2_ctl_r;
  logic signed [SUM_W-1:0] grp_r   [GROUPS];
  logic signed [SUM_W-1:0] grp_nxt [GROUPS];
  logic signed [SUM_W-1:0] acc_r;
  logic signed [SUM_W-1:0] acc_nxt;
  logic signed [SUM_W-1:0] total;
  logic                    out_valid_nxt;
  logic signed [SUM_W-1:0] dot_sum_nxt;

  // first tree level: groups of lanes
  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < GRP_SIZE; k++) begin
        grp_nxt[g] = grp_nxt[g] + prods[g*GRP_SIZE + k];
      end
    end
  end

  always_comb begin
    total = acc_r;
    for (int g = 0; g < GROUPS; g++) begin
      total = total + grp_r[g];
    end
  end

  always_comb begin
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && !out_ready;
    dot_sum_nxt   = dot_sum_r;
    if (en) begin
      out_valid_nxt = 1'b0;
      if (s2_ctl_r.valid) begin
        if (s2_ctl_r.last) begin
          acc_nxt       = '0;
          out_valid_nxt = 1'b1;
          dot_sum_nxt   = total;
        end else begin
          acc_nxt = total;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_ctl_r    <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (en) begin
        s2_ctl_r <= s1_ctl;
      end
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      grp_r <= grp_nxt;
    end
    dot_sum_r <= dot_sum_nxt;
  end

endmodule

@@ rtl/core/mixed_precision_dot_product.sv @@
// packed mixed-precision signed dot product, one word pair per beat
//
// in_ch  : valid/ready channel carrying a_word, b_word, elem_count, last.
//          the first elem_count pairs (capped at the a elements per word) are
//          sign-extended, multiplied and summed in a 32-bit wrapping accumulator
// out_ch : valid/ready channel carrying dot_sum, one beat per input beat
//          that has last set; the accumulator clears behind it
// apb    : psel/penable/pwrite/paddr/pwdata/prdata/pready, one register
//          (precision_mode at address 0), write only while idle
//
// throughput: one beat per cycle unless out_ch stalls, set by the per-lane
// multipliers and two-level adder tree, which each take a new beat every cycle
// pipe: the lane products load at the input accept edge, then the group sums,
// then the total accumulates into the output register
// stall: the whole pipe holds while out_ch has a beat pending and the
// receiver is not ready; in_ch.ready drops in the same cycle
// reset: rst_n (sync, active low) clears the pipe valids, the accumulator,
// the output valid and selects mode a16b16
module mixed_precision_dot_product
  import mdp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  mdp_in_if.sink             in_ch,
  mdp_out_if.source          out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  // config register
  logic [MODE_W-1:0] mode_r;
  logic [MODE_W-1:0] mode_nxt;
  mode_dec_t         mode_dec;

  // pipe control
  logic                    en;
  beat_ctl_t               s1_ctl_r;
  beat_ctl_t               s1_ctl_nxt;
  logic signed [SUM_W-1:0] prods [LANES];
  logic                    out_valid_r;
  logic signed [SUM_W-1:0] dot_sum_r;

  // apb: zero wait states, write lands on the access phase
  assign pready = 1'b1;

  always_comb begin
    mode_nxt = mode_r;
    if (psel && penable && pwrite && (paddr == REG_PRECISION_MODE)) begin
      mode_nxt = pwdata[MODE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == REG_PRECISION_MODE) begin
      prdata = PDATA_W'(mode_r);
    end
  end

  assign mode_dec = decode_mode(mode_r);

  // pipe advances unless the output beat is stuck
  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  always_comb begin
    s1_ctl_nxt       = s1_ctl_r;
    if (en) begin
      s1_ctl_nxt.valid = in_ch.valid;
      s1_ctl_nxt.last  = in_ch.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_A16B16;
      s1_ctl_r <= '0;
    end else begin
      mode_r   <= mode_nxt;
      s1_ctl_r <= s1_ctl_nxt;
    end
  end

  // one multiplier lane per element position
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    mdp_lane u_lane (
      .clk        (clk),
      .en         (en),
      .lane_idx   (LANE_W'(i)),
      .mode_dec   (mode_dec),
      .a_word     (in_ch.a_word),
      .b_word     (in_ch.b_word),
      .elem_count (in_ch.elem_count),
      .prod_r     (prods[i])
    );
  end

  // adder tree, accumulator and output register
  mdp_merge u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .s1_ctl      (s1_ctl_r),
    .prods       (prods),
    .out_ready   (out_ch.ready),
    .out_valid_r (out_valid_r),
    .dot_sum_r   (dot_sum_r)
  );

  assign out_ch.valid   = out_valid_r;
  assign out_ch.dot_sum = dot_sum_r;

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import mdp_pkg::*;

  // codes with no lane widths behind them, the block only passes the sum through
  localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 4'd10;
  localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 4'd15;

  // order in which the defined modes are visited after the directed part
  localparam logic [MODE_W-1:0] MODE_PLAN [10] = '{
    MODE_A16B16, MODE_A4B2, MODE_A2B2, MODE_A8B8, MODE_A16B4,
    MODE_A4B4, MODE_A8B4, MODE_A16B8, MODE_A16B2, MODE_A8B2
  };

  // idle profiles, percent of cycles that a side holds back
  localparam int SEND_IDLE [4] = '{0, 55, 0, 19};
  localparam int RECV_IDLE [4] = '{0, 0, 55, 19};

  localparam int SETTLE_CYCLES = 10;

  typedef struct {
    logic [WORD_BITS-1:0] a_word;
    logic [WORD_BITS-1:0] b_word;
    logic [CNT_W-1:0]     elem_count;
    logic                 last;
    bit                   hold;     // wait for all sums before sending
  } word_beat_t;

  logic clk = 1'b0;
  logic rst_n;

  // apb side
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // driven copies of the channel inputs, known from time zero
  logic                 drv_valid = 1'b0;
  logic [WORD_BITS-1:0] drv_a     = '0;
  logic [WORD_BITS-1:0] drv_b     = '0;
  logic [CNT_W-1:0]     drv_count = '0;
  logic                 drv_last  = 1'b0;
  logic                 rcv_ready = 1'b0;
  logic                 in_took   = 1'b0;

  word_beat_t              word_q [$];   // beats waiting for the driver
  logic signed [SUM_W-1:0] dot_sum_q [$]; // sums owed by the block

  // predictor state
  logic [MODE_W-1:0] mode_shadow = MODE_A16B16;
  logic [SUM_W-1:0]  acc_shadow  = '0;

  int idle_pct  = 0;
  int stall_pct = 0;
  int mismatches = 0;

  mdp_in_if  in_ch ();
  mdp_out_if out_ch ();

  assign in_ch.valid      = drv_valid;
  assign in_ch.a_word     = drv_a;
  assign in_ch.b_word     = drv_b;
  assign in_ch.elem_count = drv_count;
  assign in_ch.last       = drv_last;
  assign out_ch.ready     = rcv_ready;

  mixed_precision_dot_product dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------

  // a element width in bits, zero for codes without lanes
  function automatic int a_bits(input logic [MODE_W-1:0] mode);
    case (mode)
      MODE_A16B16, MODE_A16B8, MODE_A16B4, MODE_A16B2: return 16;
      MODE_A8B8, MODE_A8B4, MODE_A8B2:                 return 8;
      MODE_A4B4, MODE_A4B2:                            return 4;
      MODE_A2B2:                                       return 2;
      default:                                         return 0;
    endcase
  endfunction

  function automatic int b_bits(input logic [MODE_W-1:0] mode);
    case (mode)
      MODE_A16B16:                                 return 16;
      MODE_A8B8, MODE_A16B8:                       return 8;
      MODE_A4B4, MODE_A16B4, MODE_A8B4:            return 4;
      MODE_A2B2, MODE_A16B2, MODE_A8B2, MODE_A4B2: return 2;
      default:                                     return 0;
    endcase
  endfunction

  // a elements per word, unused codes still bounded by the full lane count
  function automatic int lanes_per_word(input logic [MODE_W-1:0] mode);
    return (a_bits(mode) == 0) ? 16 : WORD_BITS / a_bits(mode);
  endfunction

  // sign-extended element of width w at bit pos
  function automatic int lane_value(input logic [WORD_BITS-1:0] word, input int pos,
                                    input int w);
    int f;
    f = int'((word >> pos) & ((32'd1 << w) - 32'd1));
    if (f[w-1])
      f = f - (1 << w);
    return f;
  endfunction

  // wrapped sum of the valid lane products of one beat
  function automatic logic [SUM_W-1:0] beat_dot(input logic [MODE_W-1:0] mode,
                                                input logic [WORD_BITS-1:0] a,
                                                input logic [WORD_BITS-1:0] b,
                                                input logic [CNT_W-1:0] count);
    logic [SUM_W-1:0] s;
    int wa;
    int wb;
    int n;
    s  = '0;
    wa = a_bits(mode);
    wb = b_bits(mode);
    if (wa == 0)
      return s;
    n = (int'(count) > WORD_BITS / wa) ? WORD_BITS / wa : int'(count);
    for (int i = 0; i < n; i++)
      s = s + SUM_W'(lane_value(a, i * wa, wa) * lane_value(b, i * wb, wb));
    return s;
  endfunction

  // ---------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------

  task automatic push_beat(input logic [WORD_BITS-1:0] a, input logic [WORD_BITS-1:0] b,
                           input int count, input bit last, input bit hold = 1'b0);
    word_beat_t w;
    w.a_word     = a;
    w.b_word     = b;
    w.elem_count = CNT_W'(count);
    w.last       = last;
    w.hold       = hold;
    word_q.push_back(w);
  endtask

  // word with lanes of width w pushed to an extreme, or plain random
  function automatic logic [WORD_BITS-1:0] lane_word(input int w);
    logic [WORD_BITS-1:0] v;
    int pick;
    v    = $urandom;
    pick = $urandom_range(7);
    if (w == 0)
      w = 16;
    for (int p = 0; p < WORD_BITS; p++) begin
      case (pick)
        0: v[p] = ((p % w) == w - 1);   // every lane most negative
        1: v[p] = ((p % w) != w - 1);   // every lane most positive
        2: v[p] = 1'b1;                 // every lane minus one
        3: v[p] = 1'b0;
        default: ;
      endcase
    end
    return v;
  endfunction

  // mostly whole vectors (full words, short tail, last on the end), some noise
  task automatic fill_random(input logic [MODE_W-1:0] mode, input int n_beats);
    int made;
    int len;
    int per;
    int count;
    made = 0;
    per  = lanes_per_word(mode);
    while (made < n_beats) begin
      if ($urandom_range(9) < 8) begin
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++) begin
          count = per;
          if (k == len - 1) begin
            count = $urandom_range(1, per);
            // odd tails: nothing valid, or more than a word holds
            if ($urandom_range(7) == 0)
              count = $urandom_range(1) ? 0 : $urandom_range(per + 1, 31);
          end
          push_beat(lane_word(a_bits(mode)), lane_word(b_bits(mode)), count,
                    k == len - 1, k == 0 && $urandom_range(19) == 0);
        end
        made += len;
      end else begin
        push_beat($urandom, $urandom, $urandom_range(31), $urandom_range(1));
        made++;
      end
    end
  endtask

  task automatic set_profile(input int p);
    idle_pct  = SEND_IDLE[p % 4];
    stall_pct = RECV_IDLE[p % 4];
  endtask

  // wait until every beat is in and every sum is out, then let the pipe empty
  task automatic drain();
    do
      @(posedge clk);
    while (word_q.size() != 0 || drv_valid || dot_sum_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // write the mode register, then read it back
  task automatic cfg_write(input logic [MODE_W-1:0] mode);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = REG_PRECISION_MODE;
    pwdata  = PDATA_W'(mode);
    @(negedge clk);
    penable = 1'b1;
    do
      @(negedge clk);
    while (!pready);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do
      @(negedge clk);
    while (!pready);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %0t: %s expected %0d (0x%08h) got %0d (0x%08h)", $realtime, what,
               $signed(want), want, $signed(got), got);
  endtask

  // ---------------------------------------------------------------
  // driver: one beat held until taken, gaps at random
  // ---------------------------------------------------------------
  always @(negedge clk) begin
    word_beat_t w;
    if (!rst_n) begin
      drv_valid <= 1'b0;
    end else if (!drv_valid || in_took) begin
      if (word_q.size() != 0 && (!word_q[0].hold || dot_sum_q.size() == 0) &&
          $urandom_range(99) >= idle_pct) begin
        w = word_q.pop_front();
        drv_valid <= 1'b1;
        drv_a     <= w.a_word;
        drv_b     <= w.b_word;
        drv_count <= w.elem_count;
        drv_last  <= w.last;
      end else begin
        drv_valid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    rcv_ready <= ($urandom_range(99) >= stall_pct);
  end

  // ---------------------------------------------------------------
  // monitor: predict on every accepted input beat, check every output beat
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        acc_shadow = acc_shadow + beat_dot(mode_shadow, in_ch.a_word, in_ch.b_word,
                                           in_ch.elem_count);
        if (in_ch.last) begin
          dot_sum_q.push_back(acc_shadow);
          acc_shadow = '0;
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        if (dot_sum_q.size() == 0)
          flag_mismatch("dot_sum with none owed", '0, out_ch.dot_sum);
        else if (out_ch.dot_sum !== dot_sum_q[0])
          flag_mismatch("dot_sum", dot_sum_q.pop_front(), out_ch.dot_sum);
        else
          void'(dot_sum_q.pop_front());
      end
      if (psel && penable && pready && paddr == REG_PRECISION_MODE) begin
        if (pwrite)
          mode_shadow = pwdata[MODE_W-1:0];
        else if (prdata !== PDATA_W'(mode_shadow))
          flag_mismatch("precision_mode readback", PDATA_W'(mode_shadow), prdata);
      end
    end
  end

  // ---------------------------------------------------------------
  // sequence of phases
  // ---------------------------------------------------------------
  initial begin
    int phase;
    rst_n   = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = REG_PRECISION_MODE;
    pwdata  = '0;
    phase   = 0;
    set_profile(0);
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // directed, reset mode a16b16: extremes of both lanes
    push_beat(32'h7FFF_7FFF, 32'h7FFF_7FFF, 2, 1'b1);
    push_beat(32'h8000_8000, 32'h8000_8000, 2, 1'b1);   // sum reaches 2^31, wraps
    push_beat(32'h8000_7FFF, 32'h7FFF_8000, 2, 1'b1);
    push_beat(32'hFFFF_FFFF, 32'h0000_0000, 2, 1'b0);
    push_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 2, 1'b1);
    // nothing valid in the word
    push_beat(32'h1234_5678, 32'h9ABC_DEF0, 0, 1'b1);
    // tail of one, then counts past the lane count
    push_beat(32'h0003_0002, 32'h0005_0007, 1, 1'b1);
    push_beat(32'h0003_0002, 32'h0005_0007, 3, 1'b1);
    push_beat(32'h0003_0002, 32'h0005_0007, 16, 1'b1);
    push_beat(32'h0003_0002, 32'h0005_0007, 31, 1'b1);
    // long run without last wraps the accumulator all the way round
    push_beat(32'h8000_8000, 32'h8000_8000, 2, 1'b0, 1'b1);
    push_beat(32'h8000_8000, 32'h8000_8000, 2, 1'b0);
    push_beat(32'h8000_8000, 32'h8000_8000, 2, 1'b0);
    push_beat(32'h8000_8000, 32'h8000_8000, 2, 1'b0);
    push_beat(32'h0000_0000, 32'h0000_0000, 1, 1'b1);
    // partial sum left standing across the mode change below
    push_beat(32'h7FFF_0001, 32'h7FFF_0001, 2, 1'b0);
    drain();

    // unused code: the carried sum only passes through and clears
    cfg_write(MODE_UNUSED_HI);
    push_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 31, 1'b1);
    push_beat(32'h8000_8000, 32'h8000_8000, 16, 1'b1);
    drain();

    // every defined mode, each under the next idle profile in turn
    foreach (MODE_PLAN[i]) begin
      phase++;
      set_profile(phase);
      cfg_write(MODE_PLAN[i]);
      fill_random(MODE_PLAN[i], 68);
      drain();
    end

    // remaining unused codes, short
    for (int m = MODE_UNUSED_LO; m < MODE_UNUSED_HI; m++) begin
      phase++;
      set_profile(phase);
      cfg_write(MODE_W'(m));
      fill_random(MODE_W'(m), 8);
      drain();
    end

    // back to the narrowest and widest lanes
    set_profile(3);
    cfg_write(MODE_A2B2);
    fill_random(MODE_A2B2, 30);
    drain();
    set_profile(1);
    cfg_write(MODE_A16B16);
    fill_random(MODE_A16B16, 30);
    drain();

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // hang guard
  initial begin
    #3_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/mdp_pkg.sv
rtl/core/mdp_in_if.sv
rtl/core/mdp_out_if.sv
rtl/core/mdp_lane.sv
rtl/core/mdp_merge.sv
rtl/core/mixed_precision_dot_product.sv
bench/testbench.sv
